// ===== rtl/core/tsc_pkg.sv =====
// Constants, microword type and control program for the Taylor sine/cosine block.
// Holds the 1/n! table in Q2.62 and the sequencer ROM. No dependencies.
`timescale 1ns / 1ps

package tsc_pkg;

  // Fixed-point formats of the datapath
  localparam int RAD_FRAC = 28;   // radians in Q2.28
  localparam int XW       = 29;   // |x| <= pi/2
  localparam int X2W      = 30;   // x*x in Q2.28
  localparam int PW       = 64;   // running power of x
  localparam int TERMW    = 30;   // one series term
  localparam int SUMW     = 32;   // signed series sum
  localparam int LIMB     = 32;   // multiplier operand width
  localparam int PROD_W   = 128;  // product accumulator

  localparam logic [29:0]   PI_Q28    = 30'd843314857;
  localparam logic [XW-1:0] LIMIT_145 = 29'd389231411;
  localparam logic [XW-1:0] LIMIT_155 = 29'd416074956;

  typedef logic [3:0] step_t;

  // Operand A sources
  localparam logic [1:0] SRC_A_P = 2'd0;
  localparam logic [1:0] SRC_A_X = 2'd1;
  localparam logic [1:0] SRC_A_M = 2'd2;

  // Operand B sources
  localparam logic [1:0] SRC_B_INVF = 2'd0;
  localparam logic [1:0] SRC_B_X2   = 2'd1;
  localparam logic [1:0] SRC_B_X    = 2'd2;
  localparam logic [1:0] SRC_B_PI   = 2'd3;

  // Rounding constant preloaded into the accumulator
  localparam logic [1:0] RND_ANG = 2'd0;
  localparam logic [1:0] RND_Q28 = 2'd1;
  localparam logic [1:0] RND_Q62 = 2'd2;

  // Writeback targets
  localparam logic [2:0] WB_NONE = 3'd0;
  localparam logic [2:0] WB_X    = 3'd1;
  localparam logic [2:0] WB_X2   = 3'd2;
  localparam logic [2:0] WB_INIT = 3'd3;
  localparam logic [2:0] WB_TERM = 3'd4;
  localparam logic [2:0] WB_P    = 3'd5;
  localparam logic [2:0] WB_OUT  = 3'd6;

  // Branch conditions
  localparam logic [1:0] COND_NONE = 2'd0;
  localparam logic [1:0] COND_ZERO = 2'd1;  // cosine at a right angle
  localparam logic [1:0] COND_MORE = 2'd2;  // more series terms left
  localparam logic [1:0] COND_HOLD = 2'd3;  // wait for the output register

  // Program steps that are branch targets
  localparam step_t STEP_LOOP = 4'd6;
  localparam step_t STEP_FIN  = 4'd14;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_64 = 2'd2;

  typedef struct packed {
    logic       mul_en;
    logic [1:0] a_src;
    logic       a_hi;
    logic [1:0] b_src;
    logic       b_hi;
    logic [1:0] sh;
    logic       clr;
    logic [1:0] rnd;
    logic [2:0] wb;
    logic [1:0] cond;
    step_t      target;
    logic       done;
  } uword_t;

  // 1/n! in Q2.62
  function automatic logic [63:0] inv_fact(input logic [4:0] n);
    logic [63:0] v;
    unique case (n)
      5'd0:    v = 64'd4611686018427387904;
      5'd1:    v = 64'd4611686018427387904;
      5'd2:    v = 64'd2305843009213693952;
      5'd3:    v = 64'd768614336404564651;
      5'd4:    v = 64'd192153584100891163;
      5'd5:    v = 64'd38430716820228233;
      5'd6:    v = 64'd6405119470038039;
      5'd7:    v = 64'd915017067148291;
      5'd8:    v = 64'd114377133393536;
      5'd9:    v = 64'd12708570377060;
      5'd10:   v = 64'd1270857037706;
      5'd11:   v = 64'd115532457973;
      5'd12:   v = 64'd9627704831;
      5'd13:   v = 64'd740592679;
      5'd14:   v = 64'd52899477;
      5'd15:   v = 64'd3526632;
      5'd16:   v = 64'd220414;
      5'd17:   v = 64'd12966;
      5'd18:   v = 64'd720;
      5'd19:   v = 64'd38;
      5'd20:   v = 64'd2;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  // Control program, one word per step
  // fields: mul_en a_src a_hi b_src b_hi sh clr rnd wb cond target done
  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    unique case (pc)
      // x = round(m * pi / half turn)
      4'd0:  w = '{1'b1, SRC_A_M, 1'b0, SRC_B_PI, 1'b0, SH_0, 1'b1, RND_ANG,
                   WB_NONE, COND_ZERO, STEP_FIN, 1'b0};
      4'd1:  w = '0;
      4'd2:  w = '{1'b0, SRC_A_P, 1'b0, SRC_B_INVF, 1'b0, SH_0, 1'b0, RND_ANG,
                   WB_X, COND_NONE, STEP_LOOP, 1'b0};
      // x2 = round(x * x), seed the power, sum and term count
      4'd3:  w = '{1'b1, SRC_A_X, 1'b0, SRC_B_X, 1'b0, SH_0, 1'b1, RND_Q28,
                   WB_INIT, COND_NONE, STEP_LOOP, 1'b0};
      4'd4:  w = '0;
      4'd5:  w = '{1'b0, SRC_A_P, 1'b0, SRC_B_INVF, 1'b0, SH_0, 1'b0, RND_ANG,
                   WB_X2, COND_NONE, STEP_LOOP, 1'b0};
      // term = round(p * 1/n!), four partial products
      4'd6:  w = '{1'b1, SRC_A_P, 1'b0, SRC_B_INVF, 1'b0, SH_0, 1'b1, RND_Q62,
                   WB_NONE, COND_NONE, STEP_LOOP, 1'b0};
      4'd7:  w = '{1'b1, SRC_A_P, 1'b0, SRC_B_INVF, 1'b1, SH_32, 1'b0, RND_Q62,
                   WB_NONE, COND_NONE, STEP_LOOP, 1'b0};
      4'd8:  w = '{1'b1, SRC_A_P, 1'b1, SRC_B_INVF, 1'b0, SH_32, 1'b0, RND_Q62,
                   WB_NONE, COND_NONE, STEP_LOOP, 1'b0};
      4'd9:  w = '{1'b1, SRC_A_P, 1'b1, SRC_B_INVF, 1'b1, SH_64, 1'b0, RND_Q62,
                   WB_NONE, COND_NONE, STEP_LOOP, 1'b0};
      // next power p = round(p * x2), two partial products; retire the term
      4'd10: w = '{1'b1, SRC_A_P, 1'b0, SRC_B_X2, 1'b0, SH_0, 1'b1, RND_Q28,
                   WB_NONE, COND_NONE, STEP_LOOP, 1'b0};
      4'd11: w = '{1'b1, SRC_A_P, 1'b1, SRC_B_X2, 1'b0, SH_32, 1'b0, RND_Q28,
                   WB_TERM, COND_NONE, STEP_LOOP, 1'b0};
      4'd12: w = '0;
      4'd13: w = '{1'b0, SRC_A_P, 1'b0, SRC_B_INVF, 1'b0, SH_0, 1'b0, RND_Q28,
                   WB_P, COND_MORE, STEP_LOOP, 1'b0};
      // round, saturate and hand over the result
      4'd14: w = '{1'b0, SRC_A_P, 1'b0, SRC_B_INVF, 1'b0, SH_0, 1'b0, RND_Q28,
                   WB_OUT, COND_HOLD, STEP_FIN, 1'b1};
      default: w = '{1'b0, SRC_A_P, 1'b0, SRC_B_INVF, 1'b0, SH_0, 1'b0, RND_Q28,
                     WB_NONE, COND_NONE, STEP_FIN, 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/taylor_sine_cosine.sv =====
// Sine and cosine of a binary angle by Maclaurin series, microcoded datapath.
// Depends on tsc_pkg for the control program, the 1/n! table and constants.
//
// Usage:
//   Input transfer on s_*: s_tuser selects the function (0 sine, 1 cosine),
//   s_tdata carries the signed binary angle (full turn = 2^ANGLE_BITS).
//   Output transfer on m_*: m_tdata carries the value in signed
//   Q1.RESULT_FRAC_BITS, saturated to +-1.0.
//   One item is in work at a time; s_tready is high while the sequencer idles.
//   The series runs over T terms (sine 6, cosine 6, 9 or 11); cosine at a
//   right angle skips the series and goes straight to the final step.
//   Each term costs eight steps of the program around the single shared
//   32x32 multiplier: six partial products plus two pipeline slots.
//   The finished result sits in an output register; s_tready returns in the
//   same cycle as m_tvalid, so a new item runs while the result waits.
//   If the receiver still holds the previous result at the final step, the
//   sequencer waits there until m_tready frees the register.
//   Reset (rst, synchronous) empties the output register and idles the
//   sequencer; no clearing pass is needed.
`timescale 1ns / 1ps

module taylor_sine_cosine
  import tsc_pkg::*;
#(
  parameter int ANGLE_BITS       = 16,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [((ANGLE_BITS + 7) / 8) * 8 - 1:0]  s_tdata,  // angle
  input  logic                                     s_tuser,  // op
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [((RESULT_FRAC_BITS + 9) / 8) * 8 - 1:0] m_tdata  // value
);

  localparam int OUT_W = ((RESULT_FRAC_BITS + 9) / 8) * 8;
  localparam int VW    = RESULT_FRAC_BITS + 2;
  localparam int MW    = ANGLE_BITS - 1;
  localparam int MAG_W = SUMW + 2;

  localparam logic signed [ANGLE_BITS:0] RIGHT =
    {2'b00, 1'b1, {(ANGLE_BITS - 2){1'b0}}};
  localparam logic signed [ANGLE_BITS:0] HALF =
    {1'b0, 1'b1, {(ANGLE_BITS - 1){1'b0}}};
  localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << RESULT_FRAC_BITS;

  // Sequencer
  logic   busy;
  step_t  pc;
  uword_t uw;
  logic   stall;
  logic   wb_go;

  // Item registers
  logic [MW-1:0] angle_mag;
  logic          cos_op;
  logic          neg_flag;
  logic          zero_flag;

  // Datapath registers
  logic [XW-1:0]          x;
  logic [X2W-1:0]         x2;
  logic [PW-1:0]          p;
  logic signed [SUMW-1:0] sum;
  logic [3:0]             cnt;
  logic [4:0]             n;

  // Multiplier pipeline
  logic [63:0]       a_word, b_word;
  logic [LIMB-1:0]   a_limb, b_limb;
  logic [2*LIMB-1:0] mul_out;
  logic [2*LIMB-1:0] pp;
  logic [1:0]        pp_sh;
  logic              pp_clr;
  logic [1:0]        pp_rnd;
  logic              pp_vld;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] acc_base, acc_add;

  // Output register
  logic          out_valid;
  logic [VW-1:0] out_value;

  // Input fold
  logic signed [ANGLE_BITS:0] a_in, a_fold, a_abs;
  logic                       folded;
  logic                       accept;

  // Finish
  logic                 sum_neg;
  logic [SUMW-1:0]      sum_abs;
  logic [MAG_W-1:0]     mag_rnd, mag_sat;
  logic [VW-1:0]        val_out;
  logic [3:0]           terms_m1;
  logic [TERMW-1:0]     term;

  assign uw       = ucode(pc);
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign stall    = (uw.cond == COND_HOLD) && out_valid && !m_tready;
  assign wb_go    = busy && !stall;
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_value);

  // Fold the angle into -90..90 degrees
  always_comb begin
    a_in   = signed'({s_tdata[ANGLE_BITS-1], s_tdata[ANGLE_BITS-1:0]});
    folded = 1'b0;
    a_fold = a_in;
    if (a_in > RIGHT) begin
      a_fold = HALF - a_in;
      folded = 1'b1;
    end else if (a_in < -RIGHT) begin
      a_fold = -HALF - a_in;
      folded = 1'b1;
    end
    a_abs = a_fold[ANGLE_BITS] ? -a_fold : a_fold;
  end

  // Latch the item on its transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      angle_mag <= a_abs[MW-1:0];
      cos_op    <= s_tuser;
      neg_flag  <= s_tuser ? folded : a_fold[ANGLE_BITS];
      zero_flag <= s_tuser && (a_fold == RIGHT || a_fold == -RIGHT);
    end
  end

  // Step counter and branches
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (!busy) begin
      if (accept) begin
        busy <= 1'b1;
        pc   <= '0;
      end
    end else if (!stall) begin
      if (uw.done) begin
        busy <= 1'b0;
      end else if ((uw.cond == COND_ZERO && zero_flag) ||
                   (uw.cond == COND_MORE && cnt != 4'd0)) begin
        pc <= uw.target;
      end else begin
        pc <= pc + 4'd1;
      end
    end
  end

  // Select operand limbs
  always_comb begin
    unique case (uw.a_src)
      SRC_A_P: a_word = p;
      SRC_A_X: a_word = 64'(x);
      SRC_A_M: a_word = 64'(angle_mag);
      default: a_word = 64'd0;
    endcase
    unique case (uw.b_src)
      SRC_B_INVF: b_word = inv_fact(n);
      SRC_B_X2:   b_word = 64'(x2);
      SRC_B_X:    b_word = 64'(x);
      SRC_B_PI:   b_word = 64'(PI_Q28);
      default:    b_word = 64'd0;
    endcase
    a_limb = uw.a_hi ? a_word[63:32] : a_word[31:0];
    b_limb = uw.b_hi ? b_word[63:32] : b_word[31:0];
  end

  assign mul_out = a_limb * b_limb;

  // Register the partial product with its alignment
  always_ff @(posedge clk) begin
    if (rst) begin
      pp_vld <= 1'b0;
    end else begin
      pp_vld <= busy && uw.mul_en;
    end
    pp     <= mul_out;
    pp_sh  <= uw.sh;
    pp_clr <= uw.clr;
    pp_rnd <= uw.rnd;
  end

  // Accumulate, preloading the rounding constant on the first partial
  always_comb begin
    if (pp_clr) begin
      unique case (pp_rnd)
        RND_ANG: acc_base = PROD_W'(1) << (ANGLE_BITS - 2);
        RND_Q28: acc_base = PROD_W'(1) << (RAD_FRAC - 1);
        RND_Q62: acc_base = PROD_W'(1) << 61;
        default: acc_base = '0;
      endcase
    end else begin
      acc_base = prod;
    end
    unique case (pp_sh)
      SH_32:   acc_add = PROD_W'(pp) << LIMB;
      SH_64:   acc_add = PROD_W'(pp) << (2 * LIMB);
      default: acc_add = PROD_W'(pp);
    endcase
  end

  always_ff @(posedge clk) begin
    if (pp_vld) begin
      prod <= acc_base + acc_add;
    end
  end

  // Term count: fixed for sine, by magnitude of the radians for cosine
  always_comb begin
    if (!cos_op || x <= LIMIT_145) begin
      terms_m1 = 4'd5;
    end else if (x <= LIMIT_155) begin
      terms_m1 = 4'd8;
    end else begin
      terms_m1 = 4'd10;
    end
  end

  assign term = prod[62 +: TERMW];

  // Write back results of the datapath
  always_ff @(posedge clk) begin
    if (wb_go) begin
      unique case (uw.wb)
        WB_X:  x  <= prod[MW +: XW];
        WB_X2: x2 <= prod[RAD_FRAC +: X2W];
        WB_INIT: begin
          p   <= cos_op ? (PW'(1) << RAD_FRAC) : PW'(x);
          n   <= cos_op ? 5'd0 : 5'd1;
          sum <= '0;
          cnt <= terms_m1;
        end
        WB_TERM: begin
          if (n[1]) begin
            sum <= sum - signed'(SUMW'(term));
          end else begin
            sum <= sum + signed'(SUMW'(term));
          end
        end
        WB_P: begin
          p   <= prod[RAD_FRAC +: PW];
          n   <= n + 5'd2;
          cnt <= cnt - 4'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // Round the magnitude to the result format
  assign sum_neg = sum[SUMW-1];
  assign sum_abs = sum_neg ? SUMW'(-sum) : SUMW'(sum);

  if (RESULT_FRAC_BITS < RAD_FRAC) begin : g_rnd
    localparam int RSH = RAD_FRAC - RESULT_FRAC_BITS;
    assign mag_rnd = (MAG_W'(sum_abs) + (MAG_W'(1) << (RSH - 1))) >> RSH;
  end else begin : g_shl
    assign mag_rnd = MAG_W'(sum_abs) << (RESULT_FRAC_BITS - RAD_FRAC);
  end

  // Saturate and apply the sign, or force zero for cosine at a right angle
  always_comb begin
    mag_sat = (mag_rnd > ONE) ? ONE : mag_rnd;
    if (zero_flag) begin
      val_out = '0;
    end else if (neg_flag ^ sum_neg) begin
      val_out = VW'(-mag_sat);
    end else begin
      val_out = VW'(mag_sat);
    end
  end

  // Output register: fill on the final step, drain on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_go && uw.wb == WB_OUT) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go && uw.wb == WB_OUT) begin
      out_value <= val_out;
    end
  end

endmodule

// ===== rtl/core/tsc_checker.sv =====
// Port-level checks for taylor_sine_cosine, bound to the top level.
// Uses only the ports of the block; no package needed.
`timescale 1ns / 1ps

module tsc_checker #(
  parameter int ANGLE_BITS       = 16,
  parameter int RESULT_FRAC_BITS = 16
) (
  input logic                                          clk,
  input logic                                          rst,
  input logic                                          s_tvalid,
  input logic                                          s_tready,
  input logic [((ANGLE_BITS + 7) / 8) * 8 - 1:0]       s_tdata,   // angle
  input logic                                          s_tuser,   // op
  input logic                                          m_tvalid,
  input logic                                          m_tready,
  input logic [((RESULT_FRAC_BITS + 9) / 8) * 8 - 1:0] m_tdata    // value
);

  localparam int VW = RESULT_FRAC_BITS + 2;
  localparam logic signed [VW-1:0] ONE = VW'(1) << RESULT_FRAC_BITS;

  logic signed [VW-1:0] value;
  assign value = signed'(m_tdata[VW-1:0]);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  // The result never leaves -1.0..1.0
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (value <= ONE) && (value >= -ONE))
    else $error("output beyond unit range");

  // One item at a time: no second transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // Reset empties the output
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Angle transfer unused by the checks above beyond the handshake
  logic unused_in;
  assign unused_in = ^{s_tdata, s_tuser};

endmodule

bind taylor_sine_cosine tsc_checker #(
  .ANGLE_BITS      (ANGLE_BITS),
  .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
) u_tsc_checker (.*);

// ===== tb/sv/tsc_scoreboard.sv =====
// Scoreboard for taylor_sine_cosine: watches both stream channels, predicts
// each value from the accepted op and angle, and compares in order.
// Depends on nothing but the port widths of the block.
`timescale 1ns / 1ps

module tsc_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // angle
  input  logic        s_tuser,   // op
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // value, bits 17:0
  output int          mismatches,
  output int          outstanding
);

  localparam logic [63:0] PI_Q28  = 64'd843314857;
  localparam logic [63:0] LIM_145 = 64'd389231411;
  localparam logic [63:0] LIM_155 = 64'd416074956;

  // 1/n! in Q2.62, n = 20 in the top bits down to n = 0 in the lowest
  localparam logic [21*64-1:0] RECIP_FACT = {
    64'd2, 64'd38, 64'd720, 64'd12966, 64'd220414, 64'd3526632, 64'd52899477,
    64'd740592679, 64'd9627704831, 64'd115532457973, 64'd1270857037706,
    64'd12708570377060, 64'd114377133393536, 64'd915017067148291,
    64'd6405119470038039, 64'd38430716820228233, 64'd192153584100891163,
    64'd768614336404564651, 64'd2305843009213693952, 64'd4611686018427387904,
    64'd4611686018427387904
  };

  typedef struct {
    logic        cosine;
    logic [15:0] angle;
    logic [17:0] value;
  } trig_result_t;

  trig_result_t expected_values[$];

  // round(a * b / 2^sh), half up, kept to 64 bits
  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] prod;
    logic [127:0] q;
    prod = {64'd0, a} * {64'd0, b};
    q = prod >> sh;
    return q[63:0] + {63'd0, prod[sh-1]};
  endfunction

  // Sine or cosine of a binary angle in signed Q1.16
  function automatic logic [17:0] sincos_q16(logic cosine, logic [15:0] angle);
    longint      a;
    logic        flip;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] pw;
    logic [63:0] t;
    logic [63:0] mag;
    logic [17:0] v;
    longint      acc;
    int          first;
    int          nterms;
    a = longint'($signed(angle));
    flip = 1'b0;
    acc = 0;
    // fold into -90..90 degrees
    if (a > 16384) begin
      a = 32768 - a;
      flip = cosine;
    end else if (a < -16384) begin
      a = -32768 - a;
      flip = cosine;
    end
    if (cosine && (a == 16384 || a == -16384)) return 18'd0;
    if (!cosine && a < 0) flip = 1'b1;
    m = (a < 0) ? 64'(-a) : 64'(a);
    x = (m * PI_Q28 + 64'd16384) >> 15;
    x2 = (x * x + (64'd1 << 27)) >> 28;
    if (cosine) begin
      pw = 64'd1 << 28;
      first = 0;
      nterms = (x > LIM_145) ? ((x > LIM_155) ? 11 : 9) : 6;
    end else begin
      pw = x;
      first = 1;
      nterms = 6;
    end
    // alternating series sum in Q2.28
    for (int k = 0; k < nterms; k++) begin
      t = mul_round(pw, RECIP_FACT[(first + 2 * k) * 64 +: 64], 62);
      if (k % 2 == 1) acc -= longint'(t);
      else acc += longint'(t);
      pw = mul_round(pw, x2, 28);
    end
    if (acc < 0) begin
      flip = !flip;
      mag = 64'(-acc);
    end else begin
      mag = 64'(acc);
    end
    mag = (mag + 64'd2048) >> 12;
    if (mag > 64'd65536) mag = 64'd65536;
    v = mag[17:0];
    return flip ? -v : v;
  endfunction

  // Queue the prediction on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    trig_result_t want;
    if (rst) begin
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        want.cosine = s_tuser;
        want.angle = s_tdata;
        want.value = sincos_q16(s_tuser, s_tdata);
        expected_values.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected result, value %0d", $time, $signed(m_tdata[17:0]));
          mismatches++;
        end else begin
          want = expected_values.pop_front();
          if (m_tdata[17:0] !== want.value) begin
            $display("%0t: value mismatch, cosine %0b angle %0d: expected %0d, got %0d",
                     $time, want.cosine, $signed(want.angle), $signed(want.value),
                     $signed(m_tdata[17:0]));
            mismatches++;
          end
        end
      end
      outstanding <= expected_values.size();
    end
  end

endmodule

// ===== tb/sv/tb_taylor_sine_cosine.sv =====
// Top of the taylor_sine_cosine testbench: clock, reset, stimulus and verdict.
// Depends on the block, tsc_pkg through it, and tsc_scoreboard for checking.
`timescale 1ns / 1ps

module tb_taylor_sine_cosine;

  localparam logic OP_SINE   = 1'b0;
  localparam logic OP_COSINE = 1'b1;

  localparam int N_RANDOM    = 1525;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_AT    = 800;
  localparam int QUIET_FROM  = 40000;
  localparam int QUIET_TO    = 55000;
  localparam int HOLD_FROM   = 20000;
  localparam int HOLD_LEN    = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  int mismatches;
  int outstanding;
  int cyc = 0;
  int sink_cyc = 0;

  taylor_sine_cosine DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  tsc_scoreboard scoreboard (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("tb_taylor_sine_cosine: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off, and a quiet stretch
  always @(posedge clk) begin
    sink_cyc <= sink_cyc + 1;
    if (sink_cyc >= HOLD_FROM && sink_cyc < HOLD_FROM + HOLD_LEN) begin
      m_tready <= 1'b0;
    end else if (sink_cyc >= QUIET_FROM && sink_cyc < QUIET_TO) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 7);
    end
  end

  // Offer one item and hold it until the transfer
  task automatic send_angle(logic op, logic [15:0] angle);
    if ((cyc < QUIET_FROM || cyc >= QUIET_TO) && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= angle;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Random angle, weighted toward folds, thresholds and the ends of the range
  function automatic logic [15:0] pick_angle();
    logic [15:0] base;
    case ($urandom_range(0, 9))
      0: begin
        base = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        return base + 16'($urandom_range(0, 8)) - 16'd4;
      end
      1: begin
        base = $urandom_range(0, 1) ? 16'd15124 : 16'd16167;
        base = base + 16'($urandom_range(0, 16)) - 16'd8;
        return $urandom_range(0, 1) ? base : -base;
      end
      2: begin
        return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 15))
                                    : 16'h8000 + 16'($urandom_range(0, 15));
      end
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = OP_SINE;
    s_tdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero, right angles, both ends, folds and cosine term thresholds
    send_angle(OP_SINE, 16'd0);
    send_angle(OP_SINE, 16'd16384);
    send_angle(OP_SINE, -16'sd16384);
    send_angle(OP_SINE, 16'h8000);
    send_angle(OP_SINE, 16'h7fff);
    send_angle(OP_SINE, 16'd1);
    send_angle(OP_SINE, 16'hffff);
    send_angle(OP_SINE, 16'd8192);
    send_angle(OP_SINE, 16'd16383);
    send_angle(OP_SINE, 16'd16385);
    send_angle(OP_SINE, -16'sd24576);
    send_angle(OP_COSINE, 16'd0);
    send_angle(OP_COSINE, 16'd16384);
    send_angle(OP_COSINE, -16'sd16384);
    send_angle(OP_COSINE, 16'h8000);
    send_angle(OP_COSINE, 16'h7fff);
    send_angle(OP_COSINE, 16'd15124);
    send_angle(OP_COSINE, 16'd15125);
    send_angle(OP_COSINE, -16'sd16167);
    send_angle(OP_COSINE, 16'd16168);
    send_angle(OP_COSINE, 16'd24576);
    send_angle(OP_COSINE, -16'sd16385);
    send_angle(OP_COSINE, 16'd1);

    // Random items, with one pause that lets the block drain completely
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == DRAIN_AT) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        @(posedge clk);
      end
      send_angle($urandom_range(0, 1) ? OP_COSINE : OP_SINE, pick_angle());
    end
    s_tvalid <= 1'b0;

    // Drain and let the longest latency pass
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (120) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_taylor_sine_cosine: done, clean");
    end else begin
      $display("tb_taylor_sine_cosine: done, errors");
    end
    $finish;
  end

endmodule
